// ===== hdl/cart_pkg.sv =====
// Shared types and constants for the credit aging residency table.
// Depends on nothing; imported by cart_ram users and the top level.
`default_nettype none

package cart_pkg;

  // Table geometry
  localparam int NUM_ENTRIES = 1024;
  localparam int CREDIT_BITS = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int ENTRY_W     = CREDIT_BITS + 2;
  localparam int TURN_W      = 16;
  localparam int AGE_W       = ((CREDIT_BITS > TURN_W) ? CREDIT_BITS : TURN_W) + 2;

  // Stream field widths
  localparam int OPCODE_W    = 2;
  localparam int INDEX_W     = 10;
  localparam int ALIVE_W     = 11;
  localparam int STATUS_W    = 4;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 24;

  // Configuration registers
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int MIN_ALIVE_W = 11;
  localparam int CREDIT_IN_W = 8;
  localparam int CHUNK_W     = 7;
  localparam int MAX_CHUNK   = 64;

  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_ALIVE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOAD_CREDITS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIT_CREDITS  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHUNK_SIZE   = 2'd3;

  localparam logic [MIN_ALIVE_W-1:0] MIN_ALIVE_RST    = 11'd1000;
  localparam logic [CREDIT_IN_W-1:0] LOAD_CREDITS_RST = 8'd50;
  localparam logic [CREDIT_IN_W-1:0] HIT_CREDITS_RST  = 8'd1;
  localparam logic [CHUNK_W-1:0]     CHUNK_SIZE_RST   = 7'd64;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ACCESS = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] RS_HIT     = 4'd0;
  localparam logic [STATUS_W-1:0] RS_LOADED  = 4'd1;
  localparam logic [STATUS_W-1:0] RS_DUMMY   = 4'd2;
  localparam logic [STATUS_W-1:0] RS_BAD_IDX = 4'd3;
  localparam logic [STATUS_W-1:0] RS_ADDED   = 4'd4;
  localparam logic [STATUS_W-1:0] RS_FULL    = 4'd5;
  localparam logic [STATUS_W-1:0] RS_EVICTED = 4'd6;
  localparam logic [STATUS_W-1:0] RS_NONE    = 4'd7;
  localparam logic [STATUS_W-1:0] RS_SKIPPED = 4'd8;
  localparam logic [STATUS_W-1:0] RS_INVALID = 4'd9;

  // Credit limits
  localparam logic signed [CREDIT_BITS-1:0] CRED_MAX = {1'b0, {(CREDIT_BITS-1){1'b1}}};
  localparam logic signed [CREDIT_BITS-1:0] CRED_MIN = {1'b1, {(CREDIT_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ACC,
    S_COL_RD,
    S_COL_EX,
    S_COL_END,
    S_PUSH
  } state_e;

  typedef struct packed {
    logic [CREDIT_BITS-1:0] credits;
    logic                   resident;
    logic                   reloadable;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [ALIVE_W-1:0]  alive;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/cart_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/credit_aging_residency_table_top.sv =====
// Credit aging residency table: top level with sequencer and entry datapath.
// Depends on cart_pkg and cart_ram.
`default_nettype none

// Usage
// - Slave stream carries one command per transaction: tuser is the opcode
//   (add, access, collect), tdata the entry index and the add/load flags.
// - Master stream returns results: tuser is the status, tdata the entry
//   index and the resident count after the result, tlast marks the final
//   result of a command. Add and access give one result; collect gives one
//   result per eviction, or a single "none evicted" or "skipped" result.
// - Configuration: write cfg_data_i to register cfg_addr_i while cfg_we_i
//   is high; write only while no command is in flight.
// - Throughput: one command at a time. Add, bad index and skipped collect
//   pass straight to the output, access reads, modifies and writes the entry
//   RAM, and a collect reads and ages one swept entry at a time, since every
//   entry goes through the one RAM read port and the one aging unit in turn.
// - Results sit in an output register; s_axis_tready returns as soon as the
//   last result of a command has moved there, so the next command may be
//   taken while that result waits. A stalled receiver holds the sweep at the
//   next eviction until the earlier one is taken.
// - Reset: the first cycle after reset writes the resident sentinel into
//   entry 0; entries above the fill count are never read, so no clearing
//   pass is needed.
module credit_aging_residency_table_top
  import cart_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Command stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // entry_index, is_reloadable,
                                                    // is_resident, load_ok, zero pad
  input  wire logic [OPCODE_W-1:0]   s_axis_tuser,  // opcode
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // result_index, alive_count, zero pad
  output logic [STATUS_W-1:0]        m_axis_tuser,  // status
  output logic                       m_axis_tlast,  // last
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e                  st_q, st_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic [CNT_W-1:0]        alive_q, alive_d;
  logic [CNT_W-1:0]        cursor_q, cursor_d;
  logic [TURN_W-1:0]       turn_q, turn_d;
  logic                    pend_vld_q, pend_vld_d;
  logic                    out_vld_q;

  // Payload registers, no reset
  result_t                 pend_q, pend_d;
  result_t                 out_q;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic [CNT_W-1:0]        stop_q, stop_d;
  logic                    wrap_q, wrap_d;
  logic [IDX_W-1:0]        acc_idx_q, acc_idx_d;
  logic                    load_ok_q, load_ok_d;

  // Configuration
  logic [MIN_ALIVE_W-1:0]  min_alive_q;
  logic [CREDIT_IN_W-1:0]  load_credits_q;
  logic [CREDIT_IN_W-1:0]  hit_credits_q;
  logic [CHUNK_W-1:0]      chunk_size_q;

  // ---------------------------------------------------------------------
  // Entry RAM
  // ---------------------------------------------------------------------
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  entry_t                  ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;
  entry_t                  rd_entry;

  cart_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  logic                    accept;
  logic [OPCODE_W-1:0]     in_op;
  logic [INDEX_W-1:0]      in_index;
  logic                    in_rel, in_res, in_load_ok;
  logic                    in_bad_idx, add_invalid, add_full, col_skip;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_op      = s_axis_tuser;
  assign in_index   = s_axis_tdata[INDEX_W-1:0];
  assign in_rel     = s_axis_tdata[INDEX_W];
  assign in_res     = s_axis_tdata[INDEX_W+1];
  assign in_load_ok = s_axis_tdata[INDEX_W+2];

  assign in_bad_idx  = CNT_W'(in_index) >= total_q;
  assign add_invalid = !in_rel && !in_res;
  assign add_full    = total_q >= CNT_W'(NUM_ENTRIES);
  assign col_skip    = alive_q < CNT_W'(min_alive_q);

  // Sweep bounds: clamp chunk to 1..MAX_CHUNK, stop at the fill count
  logic [CHUNK_W-1:0]      chunk_eff;
  logic [CNT_W:0]          cur_plus;
  logic                    sweep_wrap;

  always_comb begin
    if (chunk_size_q == '0) begin
      chunk_eff = CHUNK_W'(1);
    end else if (chunk_size_q > CHUNK_W'(MAX_CHUNK)) begin
      chunk_eff = CHUNK_W'(MAX_CHUNK);
    end else begin
      chunk_eff = chunk_size_q;
    end
  end

  assign cur_plus   = (CNT_W+1)'(cursor_q) + (CNT_W+1)'(chunk_eff);
  assign sweep_wrap = cur_plus > (CNT_W+1)'(total_q);

  // ---------------------------------------------------------------------
  // Shared credit unit: hit add with upper saturation, aging subtract
  // with lower saturation
  // ---------------------------------------------------------------------
  logic signed [CREDIT_BITS-1:0] rd_cred;
  logic signed [AGE_W-1:0]       cred_addend;
  logic signed [AGE_W-1:0]       cred_sum;
  logic signed [CREDIT_BITS-1:0] cred_sat;
  logic                          evict;

  assign rd_cred     = rd_entry.credits;
  // Add the hit credits during an access, subtract the turn count in a sweep
  assign cred_addend = (st_q == S_ACC)
                     ? $signed({(AGE_W-CREDIT_IN_W)'(0), hit_credits_q})
                     : -$signed({(AGE_W-TURN_W)'(0), turn_q});
  assign cred_sum    = AGE_W'(rd_cred) + cred_addend;
  assign cred_sat    = (cred_sum > AGE_W'(CRED_MAX)) ? CRED_MAX :
                       (cred_sum < AGE_W'(CRED_MIN)) ? CRED_MIN :
                                                       cred_sum[CREDIT_BITS-1:0];
  assign evict       = rd_entry.reloadable && rd_entry.resident && cred_sat[CREDIT_BITS-1];

  // ---------------------------------------------------------------------
  // Output register handshake
  // ---------------------------------------------------------------------
  logic    out_free;
  logic    push;
  result_t push_data;
  logic    col_stall;

  assign out_free  = !out_vld_q || m_axis_tready;
  // An eviction must hand the earlier one on before it can be held
  assign col_stall = evict && pend_vld_q && !out_free;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_INIT: begin
        st_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ADD:    st_d = S_PUSH;
            OP_ACCESS: st_d = in_bad_idx ? S_PUSH : S_ACC;
            default:   st_d = col_skip ? S_PUSH : S_COL_RD;
          endcase
        end
      end
      S_ACC: begin
        st_d = S_PUSH;
      end
      S_COL_RD: begin
        st_d = (pos_q == stop_q) ? S_COL_END : S_COL_EX;
      end
      S_COL_EX: begin
        if (!col_stall) begin
          st_d = S_COL_RD;
        end
      end
      S_COL_END, S_PUSH: begin
        if (out_free) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and RAM control
  // ---------------------------------------------------------------------
  always_comb begin
    total_d    = total_q;
    alive_d    = alive_q;
    cursor_d   = cursor_q;
    turn_d     = turn_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    pos_d      = pos_q;
    stop_d     = stop_q;
    wrap_d     = wrap_q;
    acc_idx_d  = acc_idx_q;
    load_ok_d  = load_ok_q;
    ram_we     = 1'b0;
    ram_waddr  = acc_idx_q;
    ram_wdata  = rd_entry;
    ram_re     = 1'b0;
    ram_raddr  = IDX_W'(in_index);
    push       = 1'b0;
    push_data  = pend_q;

    case (st_q)
      S_INIT: begin
        // Place the resident sentinel in entry 0
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{credits: '0, resident: 1'b1, reloadable: 1'b0};
      end

      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ADD: begin
              pend_vld_d = 1'b1;
              if (add_invalid) begin
                pend_d = '{status: RS_INVALID, index: '0,
                           alive: ALIVE_W'(alive_q), last: 1'b1};
              end else if (add_full) begin
                pend_d = '{status: RS_FULL, index: '0,
                           alive: ALIVE_W'(alive_q), last: 1'b1};
              end else begin
                ram_we    = 1'b1;
                ram_waddr = total_q[IDX_W-1:0];
                ram_wdata = '{credits: in_res ? CREDIT_BITS'(load_credits_q) : '0,
                              resident: in_res, reloadable: in_rel};
                alive_d   = alive_q + CNT_W'(in_res);
                total_d   = total_q + CNT_W'(1);
                pend_d    = '{status: RS_ADDED, index: INDEX_W'(total_q),
                              alive: ALIVE_W'(alive_q + CNT_W'(in_res)), last: 1'b1};
              end
            end
            OP_ACCESS: begin
              if (in_bad_idx) begin
                pend_vld_d = 1'b1;
                pend_d     = '{status: RS_BAD_IDX, index: in_index,
                               alive: ALIVE_W'(alive_q), last: 1'b1};
              end else begin
                ram_re    = 1'b1;
                acc_idx_d = IDX_W'(in_index);
                load_ok_d = in_load_ok;
              end
            end
            default: begin
              if (col_skip) begin
                pend_vld_d = 1'b1;
                pend_d     = '{status: RS_SKIPPED, index: '0,
                               alive: ALIVE_W'(alive_q), last: 1'b1};
              end else begin
                turn_d = turn_q + TURN_W'(1);
                wrap_d = sweep_wrap;
                stop_d = sweep_wrap ? total_q : cur_plus[CNT_W-1:0];
                pos_d  = cursor_q;
              end
            end
          endcase
        end
      end

      S_ACC: begin
        // Read-modify-write of the accessed entry
        ram_we     = 1'b1;
        pend_vld_d = 1'b1;
        if (rd_entry.resident) begin
          ram_wdata.credits = cred_sat;
          pend_d = '{status: RS_HIT, index: INDEX_W'(acc_idx_q),
                     alive: ALIVE_W'(alive_q), last: 1'b1};
        end else begin
          ram_wdata = '{credits: CREDIT_BITS'(load_credits_q), resident: 1'b1,
                        reloadable: load_ok_q && rd_entry.reloadable};
          alive_d   = alive_q + CNT_W'(1);
          pend_d    = '{status: load_ok_q ? RS_LOADED : RS_DUMMY,
                        index: INDEX_W'(acc_idx_q),
                        alive: ALIVE_W'(alive_q + CNT_W'(1)), last: 1'b1};
        end
      end

      S_COL_RD: begin
        if (pos_q != stop_q) begin
          ram_re    = 1'b1;
          ram_raddr = pos_q[IDX_W-1:0];
        end
      end

      S_COL_EX: begin
        if (!col_stall) begin
          ram_waddr = pos_q[IDX_W-1:0];
          ram_wdata = '{credits: cred_sat, resident: rd_entry.resident && !evict,
                        reloadable: rd_entry.reloadable};
          ram_we    = rd_entry.reloadable;
          pos_d     = pos_q + CNT_W'(1);
          if (evict) begin
            alive_d = (alive_q != '0) ? alive_q - CNT_W'(1) : '0;
            // Hand on the previous eviction; it is not the last one
            if (pend_vld_q) begin
              push = 1'b1;
            end
            pend_vld_d = 1'b1;
            pend_d     = '{status: RS_EVICTED, index: INDEX_W'(pos_q),
                           alive: ALIVE_W'((alive_q != '0) ? alive_q - CNT_W'(1) : '0),
                           last: 1'b0};
          end
        end
      end

      S_COL_END: begin
        if (out_free) begin
          push       = 1'b1;
          pend_vld_d = 1'b0;
          if (pend_vld_q) begin
            push_data      = pend_q;
            push_data.last = 1'b1;
          end else begin
            push_data = '{status: RS_NONE, index: '0,
                          alive: ALIVE_W'(alive_q), last: 1'b1};
          end
          cursor_d = wrap_q ? '0 : stop_q;
          turn_d   = wrap_q ? '0 : turn_q;
        end
      end

      S_PUSH: begin
        if (out_free) begin
          push       = 1'b1;
          pend_vld_d = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_INIT;
      total_q    <= CNT_W'(1);
      alive_q    <= '0;
      cursor_q   <= '0;
      turn_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      total_q    <= total_d;
      alive_q    <= alive_d;
      cursor_q   <= cursor_d;
      turn_q     <= turn_d;
      pend_vld_q <= pend_vld_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    pos_q     <= pos_d;
    stop_q    <= stop_d;
    wrap_q    <= wrap_d;
    acc_idx_q <= acc_idx_d;
    load_ok_q <= load_ok_d;
    if (push) begin
      out_q <= push_data;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_alive_q    <= MIN_ALIVE_RST;
      load_credits_q <= LOAD_CREDITS_RST;
      hit_credits_q  <= HIT_CREDITS_RST;
      chunk_size_q   <= CHUNK_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MIN_ALIVE:    min_alive_q    <= cfg_data_i[MIN_ALIVE_W-1:0];
        CFG_LOAD_CREDITS: load_credits_q <= cfg_data_i[CREDIT_IN_W-1:0];
        CFG_HIT_CREDITS:  hit_credits_q  <= cfg_data_i[CREDIT_IN_W-1:0];
        CFG_CHUNK_SIZE:   chunk_size_q   <= cfg_data_i[CHUNK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------
  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(M_TDATA_W - INDEX_W - ALIVE_W)'(0), out_q.alive, out_q.index};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The sentinel is never counted, so alive stays below the fill count
  a_alive_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alive_q < total_q)
    else $error("alive count reached fill count");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != '0 && total_q <= CNT_W'(NUM_ENTRIES))
    else $error("fill count out of range");

  // The sweep never walks past its stop point
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_COL_RD || st_q == S_COL_EX) |-> pos_q <= stop_q)
    else $error("sweep position beyond stop");

  // No held result may be left behind when a new command is taken
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_vld_q)
    else $error("pending result while ready");

endmodule

`default_nettype wire
